FILE: sv/ucc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the case mapping for the UTF-8 case converter.
// No dependencies.
package ucc_pkg;

    localparam int CpW = 21;

    localparam logic [7:0] AsciiLimit = 8'h80;
    localparam logic [7:0] Lead3Base  = 8'hE0;
    localparam logic [7:0] Lead4Base  = 8'hF0;
    localparam logic [7:0] Lead2Base  = 8'hC0;
    localparam logic [7:0] ContBase   = 8'h80;

    localparam logic CaseLower = 1'b0;
    localparam logic CaseUpper = 1'b1;

    typedef logic [CpW-1:0] t_cp;

    typedef struct packed {
        t_cp  cp;
        logic mode;
    } t_char;

    function automatic t_cp map_lower(input t_cp c);
        t_cp r;
        r = c;
        priority if (c >= 21'h41 && c <= 21'h5A) begin
            r = c + 21'h20;
        end else if (c >= 21'hC0 && c <= 21'hDE && c != 21'hD7) begin
            r = c + 21'h20;
        end else if (c >= 21'h391 && c <= 21'h3A9 && c != 21'h3A2) begin
            r = c + 21'h20;
        end else if (c >= 21'h410 && c <= 21'h42F) begin
            r = c + 21'h20;
        end else begin
            unique case (c)
                21'h386: r = 21'h3AC;
                21'h388: r = 21'h3AD;
                21'h389: r = 21'h3AE;
                21'h38A: r = 21'h3AF;
                21'h38C: r = 21'h3CC;
                21'h38E: r = 21'h3CD;
                21'h38F: r = 21'h3CE;
                21'h3C2: r = 21'h3C3;
                default: r = c;
            endcase
        end
        return r;
    endfunction

    function automatic t_cp map_upper(input t_cp c);
        t_cp r;
        r = c;
        priority if (c >= 21'h61 && c <= 21'h7A) begin
            r = c - 21'h20;
        end else if (c >= 21'hE0 && c <= 21'hFE && c != 21'hF7) begin
            r = c - 21'h20;
        end else if (c >= 21'h3B1 && c <= 21'h3C9 && c != 21'h3C2) begin
            r = c - 21'h20;
        end else if (c >= 21'h430 && c <= 21'h44F) begin
            r = c - 21'h20;
        end else begin
            unique case (c)
                21'h3AC: r = 21'h386;
                21'h3AD: r = 21'h388;
                21'h3AE: r = 21'h389;
                21'h3AF: r = 21'h38A;
                21'h3CC: r = 21'h38C;
                21'h3CD: r = 21'h38E;
                21'h3CE: r = 21'h38F;
                default: r = c;
            endcase
        end
        return r;
    endfunction

endpackage

FILE: sv/ucc_front.sv
`timescale 1ns / 1ps
// Front end: accepts raw bytes and gathers UTF-8 sequences into code points.
// Depends on ucc_pkg.
module ucc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    input  logic           i_mode,
    output logic           o_push,
    output ucc_pkg::t_char o_char
);
    import ucc_pkg::*;

    logic [1:0] r_pending, n_pending;
    t_cp        r_accum, n_accum;

    always_comb begin
        n_pending   = r_pending;
        n_accum     = r_accum;
        o_push      = 1'b0;
        o_char.cp   = r_accum;
        o_char.mode = i_mode;
        if (i_accept) begin
            if (r_pending == 2'd0) begin
                priority if (i_byte < AsciiLimit) begin
                    n_accum   = {13'd0, i_byte};
                    o_push    = 1'b1;
                    o_char.cp = {13'd0, i_byte};
                end else if (i_byte < Lead3Base) begin
                    n_accum   = {16'd0, i_byte[4:0]};
                    n_pending = 2'd1;
                end else if (i_byte < Lead4Base) begin
                    n_accum   = {17'd0, i_byte[3:0]};
                    n_pending = 2'd2;
                end else begin
                    n_accum   = {18'd0, i_byte[2:0]};
                    n_pending = 2'd3;
                end
            end else begin
                n_accum   = {r_accum[CpW-7:0], i_byte[5:0]};
                n_pending = r_pending - 2'd1;
                if (r_pending == 2'd1) begin
                    o_push    = 1'b1;
                    o_char.cp = {r_accum[CpW-7:0], i_byte[5:0]};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_accum   <= '0;
        end else begin
            r_pending <= n_pending;
            r_accum   <= n_accum;
        end
    end

endmodule

FILE: sv/ucc_queue.sv
`timescale 1ns / 1ps
// Short queue of decoded characters between the front and back ends.
// Depends on ucc_pkg.
module ucc_queue #(
    parameter int Depth = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ucc_pkg::t_char i_char,
    input  logic           i_pop,
    output ucc_pkg::t_char o_char,
    output logic           o_full,
    output logic           o_empty
);
    import ucc_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    t_char           r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic            wr_en, rd_en;

    assign o_full  = (r_count == FullCnt);
    assign o_empty = (r_count == '0);
    assign o_char  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_char;
        end
    end

endmodule

FILE: sv/ucc_back.sv
`timescale 1ns / 1ps
// Back end: maps case, re-encodes to UTF-8 and drives the output register.
// Depends on ucc_pkg.
module ucc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  ucc_pkg::t_char i_head,
    output logic           o_head_pop,
    input  logic           i_out_take,
    output logic           o_out_valid,
    output logic [7:0]     o_out_byte,
    output logic           o_char_end
);
    import ucc_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    logic [7:0] r_byte;
    logic       r_end;
    t_cp        mapped;
    logic [1:0] last_idx;
    logic [7:0] enc [4];
    logic       load, is_last;

    always_comb begin
        mapped = (i_head.mode == CaseUpper) ? map_upper(i_head.cp) : map_lower(i_head.cp);
        enc[0] = 8'h00;
        enc[1] = 8'h00;
        enc[2] = 8'h00;
        enc[3] = 8'h00;
        priority if (mapped < 21'h80) begin
            last_idx = 2'd0;
            enc[0]   = mapped[7:0];
        end else if (mapped < 21'h800) begin
            last_idx = 2'd1;
            enc[0]   = Lead2Base | {3'd0, mapped[10:6]};
            enc[1]   = ContBase | {2'd0, mapped[5:0]};
        end else if (mapped < 21'h10000) begin
            last_idx = 2'd2;
            enc[0]   = Lead3Base | {4'd0, mapped[15:12]};
            enc[1]   = ContBase | {2'd0, mapped[11:6]};
            enc[2]   = ContBase | {2'd0, mapped[5:0]};
        end else begin
            last_idx = 2'd3;
            enc[0]   = Lead4Base | {5'd0, mapped[20:18]};
            enc[1]   = ContBase | {2'd0, mapped[17:12]};
            enc[2]   = ContBase | {2'd0, mapped[11:6]};
            enc[3]   = ContBase | {2'd0, mapped[5:0]};
        end
    end

    assign load       = i_head_valid && (!r_valid || i_out_take);
    assign is_last    = (r_idx == last_idx);
    assign o_head_pop = load && is_last;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_idx   = is_last ? 2'd0 : r_idx + 2'd1;
            n_valid = 1'b1;
        end else if (i_out_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= enc[r_idx];
            r_end  <= is_last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_char_end  = r_end;

endmodule

FILE: sv/utf8_case_convert_stream.sv
`timescale 1ns / 1ps
// UTF-8 case converter, top level: mode register, front, queue and back end.
// Depends on ucc_pkg, ucc_front, ucc_queue and ucc_back.
//
// Usage:
//   Input channel: drive i_in_byte with push high; the byte is taken on a
//   clock edge where full is low. One byte per cycle is accepted.
//   Output channel: while empty is low, o_out_byte/o_char_end show the oldest
//   byte; it is taken on an edge where pop is high. o_char_end marks the last
//   byte of each re-encoded character.
//   Config channel: i_cfg_data[0] selects lower (0) or upper (1) case; it is
//   written when i_cfg_valid and o_cfg_ready are high. o_cfg_ready is always
//   high. Write it only while no character is in flight.
//   Flow: a character enters the queue on the edge that takes its last input
//   byte; the back end then loads its bytes into the output register, one per
//   cycle while pop is high.
//   Throughput: one input byte and one output byte per cycle while full is low
//   and pop is high, set by the single-byte output register.
//   Stall: when pop is held low the output register holds, the character
//   queue (QueueDepth entries) fills and then full rises.
//   Reset: synchronous, active low; clears the decoder, queue, output and
//   selects lower case.
module utf8_case_convert_stream #(
    parameter int QueueDepth = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_char_end,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);
    import ucc_pkg::*;

    logic  r_case_mode;
    logic  in_accept, fe_push, q_full, q_empty, q_pop, out_valid;
    t_char fe_char, q_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_case_mode <= CaseLower;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_case_mode <= i_cfg_data;
        end
    end

    assign full      = q_full;
    assign in_accept = push && !q_full;

    ucc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_in_byte),
        .i_mode   (r_case_mode),
        .o_push   (fe_push),
        .o_char   (fe_char)
    );

    ucc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_char  (fe_char),
        .i_pop   (q_pop),
        .o_char  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ucc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!q_empty),
        .i_head       (q_head),
        .o_head_pop   (q_pop),
        .i_out_take   (pop),
        .o_out_valid  (out_valid),
        .o_out_byte   (o_out_byte),
        .o_char_end   (o_char_end)
    );

    assign empty = !out_valid;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for utf8_case_convert_stream: byte-level predictor plus queue-side drivers.
// Depends on ucc_pkg and the utf8_case_convert_stream RTL.
module tb_top;

    localparam int StallLimit  = 2000;
    localparam int DrainCycles = 8;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_out_word;

    class case_fold_tracker;
        t_out_word   awaited_words[$];
        logic        mode_upper;
        logic [1:0]  cont_left;
        logic [20:0] cp_acc;
        int          mismatches;
        int          words_in;
        int          words_out;
        int          chars_done;
        logic [20:0] accent_caps  [7] = '{21'h386, 21'h388, 21'h389, 21'h38A,
                                          21'h38C, 21'h38E, 21'h38F};
        logic [20:0] accent_small [7] = '{21'h3AC, 21'h3AD, 21'h3AE, 21'h3AF,
                                          21'h3CC, 21'h3CD, 21'h3CE};

        function new();
            mode_upper = ucc_pkg::CaseLower;
            cont_left  = 2'd0;
            cp_acc     = 21'd0;
            mismatches = 0;
            words_in   = 0;
            words_out  = 0;
            chars_done = 0;
        endfunction

        function bit is_shift_capital(input logic [20:0] c);
            return (c >= 21'h41 && c <= 21'h5A) ||
                   (c >= 21'hC0 && c <= 21'hDE && c != 21'hD7) ||
                   (c >= 21'h391 && c <= 21'h3A9 && c != 21'h3A2) ||
                   (c >= 21'h410 && c <= 21'h42F);
        endfunction

        function logic [20:0] fold_case(input logic [20:0] c, input logic upper_sel);
            if (upper_sel == ucc_pkg::CaseUpper) begin
                if (is_shift_capital(c - 21'h20)) return c - 21'h20;
                for (int k = 0; k < 7; k++) begin
                    if (accent_small[k] == c) return accent_caps[k];
                end
            end else begin
                if (is_shift_capital(c)) return c + 21'h20;
                for (int k = 0; k < 7; k++) begin
                    if (accent_caps[k] == c) return accent_small[k];
                end
                if (c == 21'h3C2) return 21'h3C3;
            end
            return c;
        endfunction

        // first byte in bits 31:24, then downward
        function logic [31:0] utf8_pack(input logic [20:0] c, output int n);
            logic [31:0] seq;
            seq = 32'd0;
            if (c < 21'h80) begin
                seq[31:24] = c[7:0];
                n = 1;
            end else if (c < 21'h800) begin
                seq[31:16] = {3'b110, c[10:6], 2'b10, c[5:0]};
                n = 2;
            end else if (c < 21'h10000) begin
                seq[31:8] = {4'b1110, c[15:12], 2'b10, c[11:6], 2'b10, c[5:0]};
                n = 3;
            end else begin
                seq = {5'b11110, c[20:18], 2'b10, c[17:12], 2'b10, c[11:6],
                       2'b10, c[5:0]};
                n = 4;
            end
            return seq;
        endfunction

        function void emit_char(input logic [20:0] c);
            logic [31:0] seq;
            int          n;
            t_out_word   w;
            seq = utf8_pack(fold_case(c, mode_upper), n);
            for (int i = 0; i < n; i++) begin
                w.value = seq[31-8*i -: 8];
                w.last  = (i == n - 1);
                awaited_words.insert(awaited_words.size(), w);
            end
            chars_done++;
        endfunction

        function void take_word(input logic [7:0] b);
            words_in++;
            if (cont_left == 2'd0) begin
                if (b < 8'h80) begin
                    cp_acc = {13'd0, b};
                    emit_char(cp_acc);
                end else if (b < 8'hE0) begin
                    cp_acc    = {16'd0, b[4:0]};
                    cont_left = 2'd1;
                end else if (b < 8'hF0) begin
                    cp_acc    = {17'd0, b[3:0]};
                    cont_left = 2'd2;
                end else begin
                    cp_acc    = {18'd0, b[2:0]};
                    cont_left = 2'd3;
                end
            end else begin
                cp_acc    = {cp_acc[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0) emit_char(cp_acc);
            end
        endfunction

        function void match_word(input logic [7:0] b, input logic last);
            t_out_word w;
            words_out++;
            if (awaited_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word: byte %02h end %0b", b, last);
                return;
            end
            w = awaited_words.pop_front();
            if (w.value !== b || w.last !== last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word %0d: expected %02h end %0b, got %02h end %0b",
                             words_out, w.value, w.last, b, last);
            end
        endfunction

        function int pending();
            return awaited_words.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_in_byte;
    logic       empty;
    logic       pop;
    logic [7:0] o_out_byte;
    logic       o_char_end;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_data;

    case_fold_tracker sb;
    int               snd_idle;
    int               rcv_idle;
    int               stall_cycles;

    utf8_case_convert_stream u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_byte   (i_in_byte),
        .empty       (empty),
        .pop         (pop),
        .o_out_byte  (o_out_byte),
        .o_char_end  (o_char_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(99) < snd_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (full);
        sb.take_word(b);
    endtask

    task automatic drain_outputs();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_case_mode(input logic mode);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.mode_upper = mode;
    endtask

    function automatic logic [20:0] random_code_point();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30) return 21'($urandom_range(8'h7F));
        if (pick < 45) return 21'($urandom_range(8'hFF, 8'h80));
        if (pick < 65) return 21'($urandom_range(12'h3D0, 12'h380));
        if (pick < 78) return 21'($urandom_range(12'h45F, 12'h400));
        if (pick < 85) return 21'($urandom_range(12'h7FF, 8'h80));
        if (pick < 92) return 21'($urandom_range(16'hFFFF, 12'h800));
        return 21'($urandom_range(21'h1FFFFF, 21'h10000));
    endfunction

    task automatic send_random(input int count);
        int          sent;
        int          pick;
        int          n;
        int          keep;
        logic [31:0] seq;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                push_byte(8'($urandom_range(255)));
                sent++;
            end else begin
                seq  = sb.utf8_pack(random_code_point(), n);
                // cut a few sequences short
                keep = (pick < 13 && n > 1) ? $urandom_range(n - 1, 1) : n;
                for (int i = 0; i < keep; i++) push_byte(seq[31-8*i -: 8]);
                sent += keep;
            end
        end
    endtask

    // receiver: check accepted words, pick pop for the next cycle
    initial begin
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) sb.match_word(o_out_byte, o_char_end);
            pop <= ($urandom_range(99) >= rcv_idle);
        end
    end

    initial begin
        stall_cycles = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= StallLimit) begin
                $display("watchdog: no handshake for %0d cycles", StallLimit);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        sb          = new();
        snd_idle    = 35;
        rcv_idle    = 61;
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_in_byte   <= 8'h00;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_case_mode(ucc_pkg::CaseLower);
        push_byte(8'h00);
        push_byte(8'h7F);
        push_byte(8'h41);
        push_byte(8'hC3); push_byte(8'h80);
        push_byte(8'hCE); push_byte(8'hA3);
        push_byte(8'hCF); push_byte(8'h82);
        push_byte(8'hCE); push_byte(8'h86);
        push_byte(8'hD0); push_byte(8'hAF);
        // continuation-range lead, overlong, and a code point past the Unicode limit
        push_byte(8'h80); push_byte(8'hBF);
        push_byte(8'hE0); push_byte(8'h80); push_byte(8'h80);
        push_byte(8'hFF); push_byte(8'hBF); push_byte(8'hBF); push_byte(8'hBF);
        // switch mode between lead and continuation
        push_byte(8'hCE);
        drain_outputs();
        write_case_mode(ucc_pkg::CaseUpper);
        push_byte(8'hB1);
        push_byte(8'hCF); push_byte(8'h82);

        send_random(140);
        drain_outputs();
        write_case_mode(ucc_pkg::CaseLower);
        snd_idle = 61;
        rcv_idle = 35;
        send_random(140);
        drain_outputs();
        write_case_mode(ucc_pkg::CaseUpper);
        snd_idle = 0;
        rcv_idle = 0;
        send_random(70);
        drain_outputs();
        write_case_mode(ucc_pkg::CaseLower);
        send_random(70);
        drain_outputs();

        $display("Fed %0d bytes (%0d characters), both cases, three stall mixes.",
                 sb.words_in, sb.chars_done);
        $display("Checked %0d output words; %0d mismatches, %0d words never seen.",
                 sb.words_out, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/ucc_pkg.sv
sv/ucc_front.sv
sv/ucc_queue.sv
sv/ucc_back.sv
sv/utf8_case_convert_stream.sv
tb/tb_top.sv
